// ===== rtl/core/mfkp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfkp_pkg: shared types for the message FIFO with kind purge
// Message entry, operation and status codes, chain control bundle.
// ----------------------------------------------------------------------------
package mfkp_pkg;

  typedef struct packed {
    logic [15:0] kind;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
  } entry_t;

  typedef enum logic [2:0] {
    FN_PUT   = 3'd0,
    FN_GET   = 3'd1,
    FN_PURGE = 3'd2,
    FN_FLUSH = 3'd3,
    FN_START = 3'd4,
    FN_STOP  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_ABORTED = 2'd2,
    STS_FULL    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE  = 1'b0,
    S_PURGE = 1'b1
  } state_t;

  // one answer as held in the output stage
  typedef struct packed {
    func_t   func;
    status_t status;
    entry_t  msg;
  } result_t;

  // per-cycle command to the cell row
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t data;
  } chain_ctl_t;

  localparam int FILL_W = 7;

endpackage

// ===== rtl/core/mfkp_cell.sv =====
// ----------------------------------------------------------------------------
// mfkp_cell: one queue position
// Holds one entry; takes a loaded item, or its upper neighbour's on a shift.
// ----------------------------------------------------------------------------
module mfkp_cell (
  input  logic                clk,
  input  mfkp_pkg::chain_ctl_t ctl,
  input  logic                sel,
  input  mfkp_pkg::entry_t    nbr,
  output mfkp_pkg::entry_t    data
);

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      data <= ctl.data;
    end else if (ctl.shift) begin
      data <= nbr;
    end
  end

endmodule

// ===== rtl/core/mfkp_chain.sv =====
// ----------------------------------------------------------------------------
// mfkp_chain: row of queue cells
// Cell 0 is the head. A shift moves every entry one place towards the head;
// a load writes the cell at load_idx, index taken after any shift.
// ----------------------------------------------------------------------------
module mfkp_chain #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic                 clk,
  input  mfkp_pkg::chain_ctl_t ctl,
  input  logic [IW-1:0]        load_idx,
  output mfkp_pkg::entry_t     head
);

  mfkp_pkg::entry_t cells [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mfkp_pkg::entry_t nbr;
    if (g == DEPTH - 1) begin : g_top
      assign nbr = cells[g];
    end else begin : g_mid
      assign nbr = cells[g+1];
    end
    mfkp_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .sel  (load_idx == IW'(g)),
      .nbr  (nbr),
      .data (cells[g])
    );
  end

  assign head = cells[0];

endmodule

// ===== rtl/core/message_fifo_with_kind_purge_core.sv =====
// ----------------------------------------------------------------------------
// message_fifo_with_kind_purge_core: message FIFO with purge by kind
// Bounded queue of (kind, arg, arg) messages held in a row of shift cells.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// in       | in_valid/in_stall  | func msg_kind arg_one arg_two block_wait
// out      | out_valid/out_stall| answers_func status out_kind out_arg_one
//          |                    | out_arg_two fill_count last
//
// An item is taken and its first answer, if it has one, is registered the cycle
// after (a purge of a non-empty queue answers at the end of its walk); the next
// item is taken once the answers are gone. Purge walks the cell row one entry per cycle.
// Reset clears count, flags and output stage; cell contents are not cleared.
// A stalled output holds the answer and keeps in_stall high.
// ----------------------------------------------------------------------------
module message_fifo_with_kind_purge_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [15:0] msg_kind,
  input  logic signed [31:0] arg_one,
  input  logic signed [31:0] arg_two,
  input  logic        block_wait,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  answers_func,
  output logic [1:0]  status,
  output logic [15:0] out_kind,
  output logic signed [31:0] out_arg_one,
  output logic signed [31:0] out_arg_two,
  output logic [6:0]  fill_count,
  output logic        last
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = mfkp_pkg::FILL_W;

  mfkp_pkg::state_t   state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      rem, rem_next;
  logic [CW-1:0]      kept, kept_next;
  logic [15:0]        pkind, pkind_next;
  logic               aborted, aborted_next;
  logic               waiting, waiting_next;

  logic               ovalid, ovalid_next;
  mfkp_pkg::result_t  ores, ores_next;
  logic [FW-1:0]      ofill, ofill_next;
  logic               olast, olast_next;
  logic               pvalid, pvalid_next;
  mfkp_pkg::result_t  pres, pres_next;

  mfkp_pkg::chain_ctl_t ctl;
  logic [IW-1:0]        load_idx;
  mfkp_pkg::entry_t     head;
  mfkp_pkg::entry_t     in_msg;
  logic                 take;
  logic                 keep;
  logic [CW-1:0]        kept_inc;
  logic [CW+FW-1:0]     fill_ext;

  mfkp_chain #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .load_idx (load_idx),
    .head     (head)
  );

  assign in_msg   = '{kind: msg_kind, arg_one: arg_one, arg_two: arg_two};
  assign in_stall = (state != mfkp_pkg::S_IDLE) || ovalid;
  assign take     = in_valid && !in_stall;
  assign keep     = head.kind != pkind;
  assign kept_inc = kept + CW'(keep);
  assign fill_ext = {{FW{1'b0}}, count_next};

  always_comb begin
    state_next   = state;
    count_next   = count;
    rem_next     = rem;
    kept_next    = kept;
    pkind_next   = pkind;
    aborted_next = aborted;
    waiting_next = waiting;
    ovalid_next  = ovalid;
    ores_next    = ores;
    ofill_next   = ofill;
    olast_next   = olast;
    pvalid_next  = pvalid;
    pres_next    = pres;
    ctl          = '{shift: 1'b0, load: 1'b0, data: in_msg};
    load_idx     = count[IW-1:0];

    // drain the output stage
    if (ovalid && !out_stall) begin
      if (pvalid) begin
        ores_next   = pres;
        olast_next  = 1'b1;
        pvalid_next = 1'b0;
      end else begin
        ovalid_next = 1'b0;
      end
    end

    case (state)
      mfkp_pkg::S_IDLE: begin
        if (take) begin
          ovalid_next = 1'b1;
          olast_next  = 1'b1;
          ores_next   = '{func: mfkp_pkg::func_t'(func), status: mfkp_pkg::STS_OK,
                          msg: '0};
          case (func)
            mfkp_pkg::FN_PUT: begin
              if (aborted) begin
                ores_next.status = mfkp_pkg::STS_ABORTED;
              end else if (count == CW'(QUEUE_DEPTH)) begin
                ores_next.status = mfkp_pkg::STS_FULL;
              end else if (waiting) begin
                waiting_next = 1'b0;
                olast_next   = 1'b0;
                pvalid_next  = 1'b1;
                pres_next    = '{func: mfkp_pkg::FN_GET, status: mfkp_pkg::STS_OK,
                                 msg: in_msg};
              end else begin
                ctl.load   = 1'b1;
                count_next = count + CW'(1);
              end
            end
            mfkp_pkg::FN_GET: begin
              if (aborted) begin
                ores_next.status = mfkp_pkg::STS_ABORTED;
              end else if (count != '0) begin
                ctl.shift     = 1'b1;
                count_next    = count - CW'(1);
                ores_next.msg = head;
              end else if (!block_wait) begin
                ores_next.status = mfkp_pkg::STS_EMPTY;
              end else begin
                waiting_next = 1'b1;
                ovalid_next  = 1'b0;
              end
            end
            mfkp_pkg::FN_PURGE: begin
              if (aborted) begin
                ores_next.status = mfkp_pkg::STS_ABORTED;
              end else if (count != '0) begin
                ovalid_next = 1'b0;
                state_next  = mfkp_pkg::S_PURGE;
                rem_next    = count;
                kept_next   = '0;
                pkind_next  = msg_kind;
              end
            end
            mfkp_pkg::FN_FLUSH: begin
              count_next = '0;
            end
            mfkp_pkg::FN_START: begin
              aborted_next = 1'b0;
            end
            mfkp_pkg::FN_STOP: begin
              aborted_next = 1'b1;
              if (waiting) begin
                waiting_next = 1'b0;
                olast_next   = 1'b0;
                pvalid_next  = 1'b1;
                pres_next    = '{func: mfkp_pkg::FN_GET, status: mfkp_pkg::STS_ABORTED,
                                 msg: '0};
              end
            end
            default: begin
              ovalid_next = 1'b0;
            end
          endcase
        end
      end
      mfkp_pkg::S_PURGE: begin
        // pop the head; a survivor goes behind the unvisited entries
        ctl.shift = 1'b1;
        ctl.load  = keep;
        ctl.data  = head;
        load_idx  = IW'(rem - CW'(1) + kept);
        rem_next  = rem - CW'(1);
        kept_next = kept_inc;
        if (rem == CW'(1)) begin
          count_next  = kept_inc;
          state_next  = mfkp_pkg::S_IDLE;
          ovalid_next = 1'b1;
          olast_next  = 1'b1;
          ores_next   = '{func: mfkp_pkg::FN_PURGE, status: mfkp_pkg::STS_OK, msg: '0};
        end
      end
      default: begin
        state_next = mfkp_pkg::S_IDLE;
      end
    endcase

    if (state_next != state || take) begin
      ofill_next = fill_ext[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfkp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      aborted <= 1'b0;
      waiting <= 1'b0;
      ovalid  <= 1'b0;
      pvalid  <= 1'b0;
    end else begin
      count   <= count_next;
      aborted <= aborted_next;
      waiting <= waiting_next;
      ovalid  <= ovalid_next;
      pvalid  <= pvalid_next;
    end
    rem   <= rem_next;
    kept  <= kept_next;
    pkind <= pkind_next;
    ores  <= ores_next;
    ofill <= ofill_next;
    olast <= olast_next;
    pres  <= pres_next;
  end

  assign out_valid    = ovalid;
  assign answers_func = ores.func;
  assign status       = ores.status;
  assign out_kind     = ores.msg.kind;
  assign out_arg_one  = ores.msg.arg_one;
  assign out_arg_two  = ores.msg.arg_two;
  assign fill_count   = ofill;
  assign last         = olast;

  // a waiting reader only exists on an empty queue
  a_wait_empty: assert property (@(posedge clk) disable iff (rst)
    waiting |-> count == '0)
    else $error("reader waiting with entries queued");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pvalid |-> ovalid && !olast)
    else $error("second answer pending without first on output");

  a_pend_moves_up: assert property (@(posedge clk) disable iff (rst)
    ovalid && !out_stall && pvalid |=> ovalid && olast)
    else $error("pending answer lost");

  a_purge_quiet: assert property (@(posedge clk) disable iff (rst)
    state == mfkp_pkg::S_PURGE |-> !ovalid && !waiting)
    else $error("output or waiting reader during purge walk");

endmodule

// ===== verif/message_fifo_with_kind_purge_core_tb.sv =====
// ----------------------------------------------------------------------------
// message_fifo_with_kind_purge_core_tb: self-checking bench for the message FIFO
// Drives put/get/purge/flush/start/stop and spare-code items with random gaps and output
// stalls. Each accepted item is run through a queue-based model of the FIFO,
// and every answer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module message_fifo_with_kind_purge_core_tb;

  localparam int DEPTH       = 64;
  localparam int N_ITEMS     = 1150;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 250;
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  fn;
    logic [15:0] kind;
    logic [31:0] a1;
    logic [31:0] a2;
    logic        bw;
  } msg_op_t;

  typedef struct {
    logic [2:0]       fn;
    logic [1:0]       st;
    mfkp_pkg::entry_t msg;
    logic [6:0]       fill;
    logic             last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [15:0] msg_kind = '0;
  logic signed [31:0] arg_one = '0;
  logic signed [31:0] arg_two = '0;
  logic        block_wait = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  answers_func;
  logic [1:0]  status;
  logic [15:0] out_kind;
  logic signed [31:0] out_arg_one;
  logic signed [31:0] out_arg_two;
  logic [6:0]  fill_count;
  logic        last;

  // model of the queue and its flags
  mfkp_pkg::entry_t fifo_model[$];
  bit      model_aborted;
  bit      model_parked;
  answer_t pending_answers[$];
  msg_op_t op_queue[$];

  bit in_fire, out_fire;
  int n_queued, n_total_ops, n_accepted, n_answers, n_faults, quiet_cycles;
  int n_full, n_handover, n_aborted, n_purges;
  int hold_left;
  bit hold_done;

  message_fifo_with_kind_purge_core #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .msg_kind(msg_kind),
    .arg_one(arg_one),
    .arg_two(arg_two),
    .block_wait(block_wait),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .answers_func(answers_func),
    .status(status),
    .out_kind(out_kind),
    .out_arg_one(out_arg_one),
    .out_arg_two(out_arg_two),
    .fill_count(fill_count),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_fault(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_faults++;
  endtask

  task automatic apply_message_op(input msg_op_t op);
    answer_t res[$];
    answer_t a;
    mfkp_pkg::entry_t m;
    mfkp_pkg::entry_t kept[$];
    m.kind    = op.kind;
    m.arg_one = op.a1;
    m.arg_two = op.a2;
    a.fn   = op.fn;
    a.st   = mfkp_pkg::STS_OK;
    a.msg  = '0;
    a.fill = '0;
    a.last = 1'b0;
    case (op.fn)
      mfkp_pkg::FN_PUT: begin
        if (model_aborted) begin
          a.st = mfkp_pkg::STS_ABORTED;
          res.push_back(a);
        end else if (fifo_model.size() >= DEPTH) begin
          a.st = mfkp_pkg::STS_FULL;
          n_full++;
          res.push_back(a);
        end else if (model_parked) begin
          // message goes straight to the parked reader, never queued
          model_parked = 1'b0;
          n_handover++;
          res.push_back(a);
          a.fn  = mfkp_pkg::FN_GET;
          a.msg = m;
          res.push_back(a);
        end else begin
          fifo_model.push_back(m);
          res.push_back(a);
        end
      end
      mfkp_pkg::FN_GET: begin
        if (model_aborted) begin
          a.st = mfkp_pkg::STS_ABORTED;
          res.push_back(a);
        end else if (fifo_model.size() > 0) begin
          a.msg = fifo_model.pop_front();
          res.push_back(a);
        end else if (!op.bw) begin
          a.st = mfkp_pkg::STS_EMPTY;
          res.push_back(a);
        end else begin
          model_parked = 1'b1;
        end
      end
      mfkp_pkg::FN_PURGE: begin
        if (model_aborted) begin
          a.st = mfkp_pkg::STS_ABORTED;
        end else begin
          foreach (fifo_model[i])
            if (fifo_model[i].kind != op.kind) kept.push_back(fifo_model[i]);
          fifo_model = kept;
          n_purges++;
        end
        res.push_back(a);
      end
      mfkp_pkg::FN_FLUSH: begin
        fifo_model.delete();
        res.push_back(a);
      end
      mfkp_pkg::FN_START: begin
        model_aborted = 1'b0;
        res.push_back(a);
      end
      mfkp_pkg::FN_STOP: begin
        model_aborted = 1'b1;
        res.push_back(a);
        if (model_parked) begin
          model_parked = 1'b0;
          a.fn = mfkp_pkg::FN_GET;
          a.st = mfkp_pkg::STS_ABORTED;
          res.push_back(a);
        end
      end
      default: ;
    endcase
    foreach (res[i]) begin
      res[i].fill = 7'(fifo_model.size());
      res[i].last = (i == res.size() - 1);
      if (res[i].st == mfkp_pkg::STS_ABORTED) n_aborted++;
      pending_answers.push_back(res[i]);
    end
  endtask

  task automatic add_op(input logic [2:0] fn, input logic [15:0] kind,
                        input logic [31:0] a1, input logic [31:0] a2, input logic bw);
    msg_op_t op;
    op.fn   = fn;
    op.kind = kind;
    op.a1   = a1;
    op.a2   = a2;
    op.bw   = bw;
    op_queue.push_back(op);
    n_total_ops++;
    if (fn <= mfkp_pkg::FN_STOP) n_queued++;
  endtask

  // a handful of kinds so that purges hit queued messages, with full-range ones mixed in
  function automatic logic [15:0] pick_kind();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 3));
  endfunction

  // sender: new item only when the line is empty or the last one was taken
  always @(negedge clk) begin
    msg_op_t op;
    if (!rst && (!in_valid || in_fire)) begin
      if (op_queue.size() > 0 &&
          ((n_accepted >= 250 && n_accepted < 450) || $urandom_range(0, 99) >= 20)) begin
        op = op_queue.pop_front();
        in_valid   <= 1'b1;
        func       <= op.fn;
        msg_kind   <= op.kind;
        arg_one    <= op.a1;
        arg_two    <= op.a2;
        block_wait <= op.bw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up its input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && n_answers >= 600) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (n_answers >= 250 && n_answers < 450) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin : monitor
    answer_t want;
    msg_op_t op;
    in_fire  = !rst && in_valid && !in_stall;
    out_fire = !rst && out_valid && !out_stall;
    if (out_fire) begin
      n_answers++;
      if (pending_answers.size() == 0) begin
        report_fault($sformatf("answer with none expected: func %0d status %0d",
                               answers_func, status));
      end else begin
        want = pending_answers.pop_front();
        if (answers_func !== want.fn)
          report_fault($sformatf("answer %0d answers_func %0d, want %0d",
                                 n_answers, answers_func, want.fn));
        if (status !== want.st)
          report_fault($sformatf("answer %0d status %0d, want %0d",
                                 n_answers, status, want.st));
        if (out_kind !== want.msg.kind)
          report_fault($sformatf("answer %0d out_kind %h, want %h",
                                 n_answers, out_kind, want.msg.kind));
        if (out_arg_one !== want.msg.arg_one)
          report_fault($sformatf("answer %0d out_arg_one %h, want %h",
                                 n_answers, out_arg_one, want.msg.arg_one));
        if (out_arg_two !== want.msg.arg_two)
          report_fault($sformatf("answer %0d out_arg_two %h, want %h",
                                 n_answers, out_arg_two, want.msg.arg_two));
        if (fill_count !== want.fill)
          report_fault($sformatf("answer %0d fill_count %0d, want %0d",
                                 n_answers, fill_count, want.fill));
        if (last !== want.last)
          report_fault($sformatf("answer %0d last %b, want %b",
                                 n_answers, last, want.last));
      end
    end
    if (in_fire) begin
      op.fn   = func;
      op.kind = msg_kind;
      op.a1   = arg_one;
      op.a2   = arg_two;
      op.bw   = block_wait;
      apply_message_op(op);
      n_accepted++;
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
  end

  always @(negedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d answers outstanding",
               quiet_cycles, pending_answers.size());
      $display("message_fifo_with_kind_purge_core_tb failed");
      $finish;
    end
  end

  initial begin
    int directed_ops;
    int n;
    // directed part
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_op(mfkp_pkg::FN_PUT,   16'h1234, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_op(mfkp_pkg::FN_PURGE, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_GET,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // parked reader, a second blocking get shares it, a plain get sees empty
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b1);
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b1);
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'hA5A5, 32'h1234_5678, 32'hDEAD_BEEF, 1'b0);
    // stop releases a parked reader as aborted
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b1);
    add_op(mfkp_pkg::FN_STOP,  16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'h0001, 32'h1, 32'h2, 1'b0);
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_PURGE, 16'h0001, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_FLUSH, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(FN_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_op(FN_SPARE_B, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_START, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'h0002, 32'h5, 32'h6, 1'b0);
    add_op(mfkp_pkg::FN_PUT,   16'h0003, 32'h7, 32'h8, 1'b0);
    add_op(mfkp_pkg::FN_FLUSH, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_GET,   16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_START, 16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_STOP,  16'h0000, 32'h0, 32'h0, 1'b0);
    add_op(mfkp_pkg::FN_START, 16'h0000, 32'h0, 32'h0, 1'b0);
    directed_ops = n_queued;

    // random part in short episodes
    while (n_queued < directed_ops + N_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(4, 70);
          repeat (n) begin
            add_op(mfkp_pkg::FN_PUT, pick_kind(), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
              add_op(mfkp_pkg::FN_GET, pick_kind(), $urandom, $urandom, 1'b0);
          end
        end
        3, 4: begin
          n = $urandom_range(2, 40);
          repeat (n)
            add_op(mfkp_pkg::FN_GET, pick_kind(), $urandom, $urandom,
                   $urandom_range(0, 3) == 0);
        end
        5: begin
          repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 6))
              add_op(mfkp_pkg::FN_PUT, pick_kind(), $urandom, $urandom, 1'b0);
            add_op(mfkp_pkg::FN_PURGE, pick_kind(), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
          end
        end
        6: begin
          if ($urandom_range(0, 1))
            add_op(mfkp_pkg::FN_FLUSH, pick_kind(), $urandom, $urandom, 1'b0);
          add_op(mfkp_pkg::FN_GET, pick_kind(), $urandom, $urandom, 1'b1);
          if ($urandom_range(0, 1))
            add_op(mfkp_pkg::FN_GET, pick_kind(), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
          if ($urandom_range(0, 2) != 0) begin
            add_op(mfkp_pkg::FN_PUT, pick_kind(), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
          end else begin
            add_op(mfkp_pkg::FN_STOP, pick_kind(), $urandom, $urandom, 1'b0);
            add_op(mfkp_pkg::FN_START, pick_kind(), $urandom, $urandom, 1'b0);
          end
        end
        7: begin
          add_op(mfkp_pkg::FN_STOP, pick_kind(), $urandom, $urandom,
                 1'($urandom_range(0, 1)));
          repeat ($urandom_range(1, 5))
            add_op(3'($urandom_range(0, 3)), pick_kind(), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
          add_op(mfkp_pkg::FN_START, pick_kind(), $urandom, $urandom,
                 1'($urandom_range(0, 1)));
        end
        8: add_op(mfkp_pkg::FN_FLUSH, pick_kind(), $urandom, $urandom,
                  1'($urandom_range(0, 1)));
        default: begin
          repeat ($urandom_range(1, 8))
            add_op(3'($urandom_range(0, 7)), 16'($urandom), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
        end
      endcase
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total_ops) @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d random), %0d answers checked, %0d fault(s)",
             n_accepted, n_queued - directed_ops, n_answers, n_faults);
    $display("seen %0d full refusals, %0d handovers, %0d aborted answers, %0d purges",
             n_full, n_handover, n_aborted, n_purges);
    if (n_faults == 0) begin
      $display("message_fifo_with_kind_purge_core_tb passed");
    end else begin
      $display("message_fifo_with_kind_purge_core_tb failed");
    end
    $finish;
  end

endmodule
